@@ hw/rtl/vbsc_pkg.sv @@
package vbsc_pkg;

    localparam int NUM_ITEMS      = 256;
    localparam int NUM_TRANS      = 1024;
    localparam int WORD_BITS      = 64;
    localparam int WORDS_PER_ITEM = NUM_TRANS / WORD_BITS;

    localparam int ITEM_W    = 8;
    localparam int TRANS_W   = 10;
    localparam int WSEL_W    = $clog2(WORDS_PER_ITEM);
    localparam int BSEL_W    = $clog2(WORD_BITS);
    localparam int ADDR_W    = ITEM_W + WSEL_W;
    localparam int MEM_DEPTH = NUM_ITEMS * WORDS_PER_ITEM;

    localparam int COUNT_W   = 11;
    localparam int PCNT_W    = $clog2(WORD_BITS + 1);
    localparam int NTRANS_W  = 11;
    localparam int MINSUP_W  = 17;
    localparam int THR_W     = NTRANS_W + MINSUP_W;
    localparam int FRAC_BITS = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Depth of the command queue and of the result queue.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic OP_MARK  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TRANS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SUPPORT = 2'd1;

    typedef enum logic [1:0] {
        K_MARK,
        K_MEMBER,
        K_LAST
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [ITEM_W-1:0]  item;
        logic [TRANS_W-1:0] trans;
    } t_cmd;

    typedef struct packed {
        logic [COUNT_W-1:0] support_count;
        logic               frequent;
    } t_result;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MARK,
        S_QUERY,
        S_DONE
    } t_state;

endpackage

@@ hw/rtl/vertical_bitmap_support_counter.sv @@
// Vertical bitmap support counter. Mark beats (opcode 0) set one transaction bit in an
// item's 1024-bit bitmap; query beats (opcode 1) AND the named item's bitmap into an
// accumulator, and the beat with last set returns one result: the popcount of the
// intersection and a frequent flag (count * 65536 >= min_support * num_transactions).
// After reset the bitmap store is cleared one 64-bit word per cycle, all 4096 words, with
// full held high; configuration writes are taken throughout. A mark reads one word
// through the single read port of the bitmap memory and writes it back; a query member
// reads 16 words, one word per cycle, and the closing member then waits until the
// result queue has room. A two-entry command queue and a two-entry result queue
// decouple the engine from both sides. Write configuration only while the block is idle.
module vertical_bitmap_support_counter import vbsc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_opcode,
    input  logic [ITEM_W-1:0]     i_item_index,
    input  logic [TRANS_W-1:0]    i_transaction_index,
    input  logic                  i_last,
    output logic                  empty,
    input  logic                  pop,
    output logic [COUNT_W-1:0]    o_support_count,
    output logic                  o_frequent,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [NTRANS_W-1:0] r_num_trans;
    logic [MINSUP_W-1:0] r_min_support;
    logic [THR_W-1:0]    r_threshold;

    logic    w_cmd_valid;
    t_cmd    w_cmd;
    logic    w_cmd_pop;
    logic    w_res_full;
    logic    w_res_push;
    t_result w_res;
    logic    w_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_trans   <= NTRANS_W'(1);
            r_min_support <= MINSUP_W'(6554);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUM_TRANS:   r_num_trans   <= i_cfg_wdata[NTRANS_W-1:0];
                CFG_MIN_SUPPORT: r_min_support <= i_cfg_wdata[MINSUP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_threshold <= {{NTRANS_W{1'b0}}, r_min_support} * {{MINSUP_W{1'b0}}, r_num_trans};
    end

    vbsc_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_opcode            (i_opcode),
        .i_item_index        (i_item_index),
        .i_transaction_index (i_transaction_index),
        .i_last              (i_last),
        .i_hold              (w_clearing),
        .o_cmd_valid         (w_cmd_valid),
        .o_cmd               (w_cmd),
        .i_cmd_pop           (w_cmd_pop)
    );

    vbsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_threshold (r_threshold),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .o_clearing  (w_clearing)
    );

    vbsc_result u_result (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (w_res_push),
        .i_res           (w_res),
        .o_full          (w_res_full),
        .empty           (empty),
        .pop             (pop),
        .o_support_count (o_support_count),
        .o_frequent      (o_frequent)
    );

endmodule

@@ hw/rtl/vbsc_front.sv @@
module vbsc_front import vbsc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_opcode,
    input  logic [ITEM_W-1:0]  i_item_index,
    input  logic [TRANS_W-1:0] i_transaction_index,
    input  logic               i_last,
    input  logic               i_hold,
    output logic               o_cmd_valid,
    output t_cmd               o_cmd,
    input  logic               i_cmd_pop
);

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    t_cmd              w_cmd;
    logic              w_push;
    logic              w_pop;

    always_comb begin
        w_cmd.item  = i_item_index;
        w_cmd.trans = i_transaction_index;
        if (i_opcode == OP_MARK) begin
            w_cmd.kind = K_MARK;
        end else if (i_last) begin
            w_cmd.kind = K_LAST;
        end else begin
            w_cmd.kind = K_MEMBER;
        end
    end

    assign full        = i_hold || (r_cnt == QCNT_W'(QDEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = push && !full;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("command queue count out of range");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("command queue count missed a push");

endmodule

@@ hw/rtl/vbsc_result.sv @@
module vbsc_result import vbsc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_result            i_res,
    output logic               o_full,
    output logic               empty,
    input  logic               pop,
    output logic [COUNT_W-1:0] o_support_count,
    output logic               o_frequent
);

    t_result           r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_full          = (r_cnt == QCNT_W'(QDEPTH));
    assign empty           = (r_cnt == '0);
    assign o_support_count = r_q[r_rp].support_count;
    assign o_frequent      = r_q[r_rp].frequent;
    assign w_push          = i_push && !o_full;
    assign w_pop           = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("result beat offered to a full result queue");

endmodule

@@ hw/rtl/vbsc_back.sv @@
module vbsc_back import vbsc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    input  logic [THR_W-1:0] i_threshold,
    input  logic             i_res_full,
    output logic             o_res_push,
    output t_result          o_res,
    output logic             o_clearing
);

    logic [WORD_BITS-1:0] r_mem [MEM_DEPTH];
    logic [WORD_BITS-1:0] r_rdata;
    logic [WORD_BITS-1:0] r_acc [WORDS_PER_ITEM];

    t_state              r_state;
    t_state              n_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [ITEM_W-1:0]   r_item;
    logic                r_last;
    logic [ADDR_W-1:0]   r_waddr;
    logic [BSEL_W-1:0]   r_bit;
    logic [WSEL_W:0]     r_rd_cnt;
    logic                r_rd_vld;
    logic [WSEL_W-1:0]   r_rd_word;
    logic [COUNT_W-1:0]  r_count;

    logic                 w_rd_en;
    logic [ADDR_W-1:0]    w_rd_addr;
    logic                 w_we;
    logic [ADDR_W-1:0]    w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic                 w_issue;
    logic                 w_start;
    logic [WORD_BITS-1:0] w_and;

    function automatic logic [PCNT_W-1:0] popcount(input logic [WORD_BITS-1:0] x);
        logic [PCNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            n = n + PCNT_W'(x[i]);
        end
        return n;
    endfunction

    assign w_start    = (r_state == S_IDLE) && i_cmd_valid;
    assign w_and      = r_acc[r_rd_word] & r_rdata;
    assign o_clearing = (r_state == S_CLEAR);

    // The threshold is min_support * num_transactions; compare count * 2^16 against it.
    assign o_res.support_count = r_count;
    assign o_res.frequent      = (THR_W'({r_count, {FRAC_BITS{1'b0}}}) >= i_threshold);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = (i_cmd.kind == K_MARK) ? S_MARK : S_QUERY;
                end
            end
            S_MARK: begin
                n_state = S_IDLE;
            end
            S_QUERY: begin
                if (r_rd_vld && (r_rd_word == WSEL_W'(WORDS_PER_ITEM - 1))) begin
                    n_state = r_last ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        w_rd_en    = 1'b0;
        w_rd_addr  = {r_item, r_rd_cnt[WSEL_W-1:0]};
        w_we       = 1'b0;
        w_waddr    = r_waddr;
        w_wdata    = r_rdata | (WORD_BITS'(1) << r_bit);
        w_issue    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
            end
            S_IDLE: begin
                o_cmd_pop = 1'b1;
                w_rd_en   = i_cmd_valid && (i_cmd.kind == K_MARK);
                w_rd_addr = {i_cmd.item, i_cmd.trans[TRANS_W-1 -: WSEL_W]};
            end
            S_MARK: begin
                w_we = 1'b1;
            end
            S_QUERY: begin
                w_issue = !r_rd_cnt[WSEL_W];
                w_rd_en = w_issue;
            end
            S_DONE: begin
                o_res_push = !i_res_full;
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_item  <= i_cmd.item;
            r_last  <= (i_cmd.kind == K_LAST);
            r_waddr <= {i_cmd.item, i_cmd.trans[TRANS_W-1 -: WSEL_W]};
            r_bit   <= i_cmd.trans[BSEL_W-1:0];
        end
        if (w_issue) begin
            r_rd_word <= r_rd_cnt[WSEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_rd_cnt   <= '0;
            r_rd_vld   <= 1'b0;
            r_count    <= '0;
            for (int i = 0; i < WORDS_PER_ITEM; i++) begin
                r_acc[i] <= '1;
            end
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_issue;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_start) begin
                r_rd_cnt <= '0;
            end else if (w_issue) begin
                r_rd_cnt <= r_rd_cnt + 1'b1;
            end
            // On the closing member the word is counted and the accumulator refilled.
            if (r_rd_vld) begin
                r_acc[r_rd_word] <= r_last ? '1 : w_and;
                if (r_last) begin
                    r_count <= r_count + COUNT_W'(popcount(w_and));
                end
            end
            if (o_res_push) begin
                r_count <= '0;
            end
        end
    end

    a_rd_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_QUERY))
        else $error("bitmap word returned outside a query");

    a_all_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> r_rd_cnt[WSEL_W])
        else $error("result beat before all bitmap words were read");

    a_acc_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_acc[0] == '1))
        else $error("accumulator not refilled after closing member");

endmodule
